### rtl/abs_pkg.sv
// Shared types and constants for the adaptive background subtraction block.
// Register indexes, reset values and the stream payload widths.
// No dependencies.
`default_nettype none

package abs_pkg;

  // Stream payload widths
  localparam int PIXEL_W   = 8;
  localparam int S_USER_W  = 2;
  localparam int M_USER_W  = 1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_THRESHOLD     = 3'd0;
  localparam cfg_index_t REG_FAST_RATIO    = 3'd1;
  localparam cfg_index_t REG_SLOW_RATIO    = 3'd2;
  localparam cfg_index_t REG_SETTLE_FRAMES = 3'd3;
  localparam cfg_index_t REG_LEARN_FRAMES  = 3'd4;

  // Register reset values (ratios are keep factors in Q0.16)
  localparam logic [7:0]  THRESHOLD_RST     = 8'd20;
  localparam logic [15:0] FAST_RATIO_RST    = 16'd60293;
  localparam logic [15:0] SLOW_RATIO_RST    = 16'd65405;
  localparam logic [9:0]  SETTLE_FRAMES_RST = 10'd100;
  localparam logic [7:0]  LEARN_FRAMES_RST  = 8'd30;

  // Saturation limits of the frame counters
  localparam logic [7:0]  SEEN_MAX  = 8'd255;
  localparam logic [9:0]  SINCE_MAX = 10'd1023;

  // Q0.16 unity and rounding half
  localparam logic [16:0] RATIO_ONE  = 17'h10000;
  localparam logic [16:0] ROUND_HALF = 17'h08000;

endpackage

`default_nettype wire

### rtl/adaptive_background_subtraction.sv
// Top level: running-average background subtraction over a raster pixel stream.
// Depends on abs_pkg (constants) and abs_ram (background frame memory).
//
//  channel  | direction | tdata        | tuser
//  ---------+-----------+--------------+-----------------------------------
//  s_*      | in        | [7:0] pixel  | [0] frame_start, [1] shutter_changed
//  m_*      | out       | [7:0] diff.  | [0] foreground
//  cfg_*    | in        | write only: cfg_we, cfg_index, cfg_data
//
// Four register stages: memory read, background select and difference,
// the two blend multiplies, then sum/round/write-back and the output register.
// One pixel per cycle while no address hazard or output stall holds the pipe.
// A pixel whose address matches one of the two words just ahead of it waits
// until the older one reaches the write-back stage.
// A stall on m_tready freezes every stage and the memory read register.
// rst is synchronous; the background memory is not cleared.
`default_nettype none

module adaptive_background_subtraction #(
  parameter int FRAME_WIDTH   = 320,
  parameter int FRAME_HEIGHT  = 240,
  parameter int FRACTION_BITS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // pixel input
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [abs_pkg::PIXEL_W-1:0]          s_tdata,   // [7:0] pixel
  input  wire  [abs_pkg::S_USER_W-1:0]         s_tuser,   // [0] frame_start, [1] shutter_changed
  // result output
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [abs_pkg::PIXEL_W-1:0]          m_tdata,   // [7:0] difference
  output logic [abs_pkg::M_USER_W-1:0]         m_tuser,   // [0] foreground
  // configuration writes
  input  wire                                  cfg_we,
  input  wire  [abs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [abs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BG_W   = abs_pkg::PIXEL_W + FRACTION_BITS;
  localparam int KEEP_W = BG_W + 16;
  localparam int NEW_W  = BG_W + 17;
  localparam int SUM_W  = BG_W + 18;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // configuration registers
  logic [7:0]  threshold;
  logic [15:0] fast_ratio;
  logic [15:0] slow_ratio;
  logic [9:0]  settle_frames;
  logic [7:0]  learn_frames;

  // frame state
  logic              started;
  logic [ADDR_W-1:0] pixel_address;
  logic [7:0]        frames_seen;
  logic [9:0]        frames_since_change;

  // stage 0 (input) signals
  logic              frame_start;
  logic              shutter_changed;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W-1:0] addr_next;
  logic [7:0]        frames_seen_next;
  logic [9:0]        frames_since_change_next;
  logic              hazard;
  logic              adv;
  logic              accept;

  // stage 1: memory data arrives
  logic                       p1_valid;
  logic [ADDR_W-1:0]          p1_addr;
  logic [abs_pkg::PIXEL_W-1:0] p1_pixel;
  logic                       p1_learn;
  logic [15:0]                p1_ratio;
  logic                       p1_fwd_hit;
  logic [BG_W-1:0]            p1_fwd_data;
  logic [BG_W-1:0]            ram_rdata;
  logic [BG_W-1:0]            p1_target;
  logic [BG_W-1:0]            p1_bg;
  logic [7:0]                 p1_bg_int;
  logic [7:0]                 p1_diff;

  // stage 2: multiply operands
  logic                       p2_valid;
  logic [ADDR_W-1:0]          p2_addr;
  logic [BG_W-1:0]            p2_bg;
  logic [BG_W-1:0]            p2_target;
  logic [15:0]                p2_ratio;
  logic [16:0]                p2_inv_ratio;
  logic [7:0]                 p2_diff;
  logic                       p2_fg;

  // stage 3: products, sum and write-back
  logic                       p3_valid;
  logic [ADDR_W-1:0]          p3_addr;
  logic [KEEP_W-1:0]          p3_keep;
  logic [NEW_W-1:0]           p3_new;
  logic [7:0]                 p3_diff;
  logic                       p3_fg;
  logic [SUM_W-1:0]           p3_sum;
  logic [BG_W-1:0]            p3_blend;

  // output register
  logic                       out_valid;
  logic [7:0]                 out_diff;
  logic                       out_fg;

  // frame bookkeeping for the incoming word
  always_comb begin
    frame_start     = s_tuser[0];
    shutter_changed = s_tuser[1];
    addr_cur        = frame_start ? '0 : pixel_address;
    addr_next       = (addr_cur == LAST_ADDR) ? '0 : addr_cur + 1'b1;

    frames_seen_next         = frames_seen;
    frames_since_change_next = frames_since_change;
    if (frame_start) begin
      if (started && frames_seen != abs_pkg::SEEN_MAX) begin
        frames_seen_next = frames_seen + 1'b1;
      end
      if (started && frames_since_change != abs_pkg::SINCE_MAX) begin
        frames_since_change_next = frames_since_change + 1'b1;
      end
      if (shutter_changed) begin
        frames_since_change_next = '0;
      end
    end
  end

  // flow control: the whole pipe moves together; hold a word whose address
  // is still being updated in stage 1 or 2
  always_comb begin
    adv      = !out_valid || m_tready;
    hazard   = (p1_valid && p1_addr == addr_cur) || (p2_valid && p2_addr == addr_cur);
    s_tready = adv && !hazard;
    accept   = s_tvalid && s_tready;
  end

  // configuration and frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold           <= abs_pkg::THRESHOLD_RST;
      fast_ratio          <= abs_pkg::FAST_RATIO_RST;
      slow_ratio          <= abs_pkg::SLOW_RATIO_RST;
      settle_frames       <= abs_pkg::SETTLE_FRAMES_RST;
      learn_frames        <= abs_pkg::LEARN_FRAMES_RST;
      started             <= 1'b0;
      pixel_address       <= '0;
      frames_seen         <= '0;
      frames_since_change <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          abs_pkg::REG_THRESHOLD:     threshold     <= cfg_data[7:0];
          abs_pkg::REG_FAST_RATIO:    fast_ratio    <= cfg_data[15:0];
          abs_pkg::REG_SLOW_RATIO:    slow_ratio    <= cfg_data[15:0];
          abs_pkg::REG_SETTLE_FRAMES: settle_frames <= cfg_data[9:0];
          abs_pkg::REG_LEARN_FRAMES:  learn_frames  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_start) begin
          started <= 1'b1;
        end
        pixel_address       <= addr_next;
        frames_seen         <= frames_seen_next;
        frames_since_change <= frames_since_change_next;
      end
    end
  end

  // background frame memory
  abs_ram #(
    .WIDTH (BG_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (adv && p3_valid),
    .waddr (p3_addr),
    .wdata (p3_blend),
    .re    (adv),
    .raddr (addr_cur),
    .rdata (ram_rdata)
  );

  // stage 1: pick forwarded or stored background, learning override, difference
  always_comb begin
    p1_target = BG_W'(p1_pixel) << FRACTION_BITS;
    p1_bg     = p1_fwd_hit ? p1_fwd_data : ram_rdata;
    if (p1_learn) begin
      p1_bg = p1_target;
    end
    p1_bg_int = p1_bg[BG_W-1 -: 8];
    p1_diff   = (p1_pixel > p1_bg_int) ? p1_pixel - p1_bg_int : 8'd0;
  end

  // stage 3: round and scale the blend back to background width
  always_comb begin
    p3_sum   = SUM_W'(p3_keep) + SUM_W'(p3_new) + SUM_W'(abs_pkg::ROUND_HALF);
    p3_blend = p3_sum[BG_W+15:16];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= accept;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: the word being written back now is newer than the memory read
      p1_addr     <= addr_cur;
      p1_pixel    <= s_tdata[7:0];
      p1_learn    <= frames_seen_next < learn_frames;
      p1_ratio    <= (frames_since_change_next < settle_frames) ? fast_ratio : slow_ratio;
      p1_fwd_hit  <= p3_valid && p3_addr == addr_cur;
      p1_fwd_data <= p3_blend;
      // stage 2
      p2_addr      <= p1_addr;
      p2_bg        <= p1_bg;
      p2_target    <= p1_target;
      p2_ratio     <= p1_ratio;
      p2_inv_ratio <= abs_pkg::RATIO_ONE - {1'b0, p1_ratio};
      p2_diff      <= p1_diff;
      p2_fg        <= p1_diff > threshold;
      // stage 3: keep and new-pixel products
      p3_addr <= p2_addr;
      p3_keep <= KEEP_W'(p2_bg) * KEEP_W'(p2_ratio);
      p3_new  <= NEW_W'(p2_target) * NEW_W'(p2_inv_ratio);
      p3_diff <= p2_diff;
      p3_fg   <= p2_fg;
      // output register
      out_diff <= p3_diff;
      out_fg   <= p3_fg;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_diff;
  assign m_tuser  = out_fg;

endmodule

`default_nettype wire

### rtl/abs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the per-pixel background image. No dependencies.
`default_nettype none

module abs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 76800
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                         wdata,
  input  wire                                     re,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/abs_checker.sv
// Port-level checks for the adaptive background subtraction block, and the
// bind that attaches them to the top level. Depends on abs_pkg.
`default_nettype none

module abs_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [abs_pkg::PIXEL_W-1:0]       m_tdata,
  input wire [abs_pkg::M_USER_W-1:0]      m_tuser
);

  // a stalled output word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // a stalled output freezes the pipe, so no input word is taken
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // foreground needs a difference above a threshold of at least zero
  a_fg_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata != '0)
    else $error("foreground flagged with zero difference");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind adaptive_background_subtraction abs_checker u_abs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
